// File: hw/rtl/drop_tail_fifo_rate_drain_macros.svh
// ----------------------------------------------------------------------------
// drop_tail_fifo_rate_drain_macros.svh
// assertion shorthands used by the checker in dtf_checker.sv
// ----------------------------------------------------------------------------
`ifndef DROP_TAIL_FIFO_RATE_DRAIN_MACROS_SVH
`define DROP_TAIL_FIFO_RATE_DRAIN_MACROS_SVH

// same-cycle implication, disabled during reset
`define DTF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define DTF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/dtf_pkg.sv
// ----------------------------------------------------------------------------
// dtf_pkg
// shared constants and control types for the drop-tail queue with credit drain
// ----------------------------------------------------------------------------
package dtf_pkg;

  // queue storage
  localparam int QUEUE_DEPTH = 128;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);

  // field widths
  localparam int CNT_W       = 8;
  localparam int BYTES_W     = 16;
  localparam int TICK_W      = 32;
  localparam int TOTAL_W     = 32;
  localparam int DLY_SUM_W   = 40;
  localparam int DLY_TOT_W   = 48;
  localparam int ENTRY_W     = BYTES_W + TICK_W;

  // credit format
  localparam int FRAC_BITS   = 16;
  localparam int CREDIT_W    = 34;
  localparam int RATE_W      = 24;
  localparam int LIMIT_W     = 8;
  localparam logic [CREDIT_W-1:0] CREDIT_MAX = {CREDIT_W{1'b1}};
  localparam logic [CNT_W-1:0]    DEPTH_CNT  = CNT_W'(QUEUE_DEPTH);

  // configuration port
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 24;
  localparam logic [CFG_IDX_W-1:0] CFG_CREDIT_PER_TICK = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_QUEUE_LIMIT     = 1'b1;
  localparam logic [RATE_W-1:0]    RATE_RESET          = RATE_W'(94489);
  localparam logic [LIMIT_W-1:0]   LIMIT_RESET         = LIMIT_W'(100);

  // controller to datapath commands
  typedef struct packed {
    logic accept;   // take the arrival and update credit
    logic rd;       // read the head entry
    logic depart;   // deliver the head entry
    logic finish;   // result beat shown, advance the tick
  } dtf_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic nonempty;
    logic covers;
  } dtf_stat_t;

endpackage

// File: hw/rtl/dtf_ctrl.sv
// ----------------------------------------------------------------------------
// dtf_ctrl
// tick sequencer: arrival, head read and credit check loop, result beat
// ----------------------------------------------------------------------------
module dtf_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  dtf_pkg::dtf_stat_t stat,
  output dtf_pkg::dtf_cmd_t  cmd,
  output logic              busy,
  output logic              done
);
  import dtf_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_READ  = 2'd1;
  localparam logic [1:0] S_CHECK = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.accept = 1'b1;
          state_next = S_READ;
        end
      end
      S_READ: begin
        if (stat.nonempty) begin
          cmd.rd     = 1'b1;
          state_next = S_CHECK;
        end else begin
          state_next = S_DONE;
        end
      end
      S_CHECK: begin
        if (stat.covers) begin
          cmd.depart = 1'b1;
          state_next = S_READ;
        end else begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        cmd.finish = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE);

endmodule

// File: hw/rtl/dtf_datapath.sv
// ----------------------------------------------------------------------------
// dtf_datapath
// packet store, pointers, byte credit, counters and per-tick result registers
// ----------------------------------------------------------------------------
module dtf_datapath (
  input  logic                           clk,
  input  logic                           rst,
  input  dtf_pkg::dtf_cmd_t              cmd,
  output dtf_pkg::dtf_stat_t             stat,
  input  logic                           arrival_valid,
  input  logic [dtf_pkg::BYTES_W-1:0]    packet_bytes,
  input  logic                           wr_en,
  input  logic [dtf_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [dtf_pkg::CFG_DATA_W-1:0] wr_data,
  output logic                           arrival_accepted,
  output logic                           arrival_dropped,
  output logic [dtf_pkg::CNT_W-1:0]      departed_count,
  output logic [dtf_pkg::DLY_SUM_W-1:0]  departed_delay_sum,
  output logic [dtf_pkg::CNT_W-1:0]      occupancy,
  output logic [dtf_pkg::TOTAL_W-1:0]    total_arrived,
  output logic [dtf_pkg::TOTAL_W-1:0]    total_delivered,
  output logic [dtf_pkg::TOTAL_W-1:0]    total_dropped,
  output logic [dtf_pkg::DLY_TOT_W-1:0]  cumulative_delay,
  output logic [dtf_pkg::TICK_W-1:0]     current_tick
);
  import dtf_pkg::*;

  // packet store: size and arrival tick per slot
  logic [ENTRY_W-1:0] store [QUEUE_DEPTH];
  logic [ENTRY_W-1:0] rd_entry;

  logic [RATE_W-1:0]    credit_per_tick;
  logic [LIMIT_W-1:0]   queue_limit;
  logic [PTR_W-1:0]     head;
  logic [PTR_W-1:0]     tail;
  logic [CNT_W-1:0]     held;
  logic [CREDIT_W-1:0]  credit;
  logic [TICK_W-1:0]    tick;
  logic [TOTAL_W-1:0]   arrived;
  logic [TOTAL_W-1:0]   delivered;
  logic [TOTAL_W-1:0]   dropped;
  logic [DLY_TOT_W-1:0] delay_acc;

  logic                 full;
  logic                 arr_ok;
  logic [CNT_W-1:0]     held_inc;
  logic [CREDIT_W:0]    credit_sum;
  logic [CREDIT_W-1:0]  credit_upd;
  logic [BYTES_W-1:0]   rd_bytes;
  logic [TICK_W-1:0]    rd_tick;
  logic [CREDIT_W-1:0]  need;
  logic [TICK_W-1:0]    delay;

  function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
    next_slot = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // arrival admission and credit refill
  always_comb begin
    full       = (held >= CNT_W'(queue_limit)) || (held >= DEPTH_CNT);
    arr_ok     = arrival_valid && !full;
    held_inc   = held + CNT_W'(arr_ok);
    credit_sum = {1'b0, credit} + (CREDIT_W+1)'(credit_per_tick);
    if (held_inc == '0) begin
      credit_upd = '0;
    end else if (credit_sum[CREDIT_W]) begin
      credit_upd = CREDIT_MAX;
    end else begin
      credit_upd = credit_sum[CREDIT_W-1:0];
    end
  end

  // head entry check
  assign rd_bytes      = rd_entry[ENTRY_W-1:TICK_W];
  assign rd_tick       = rd_entry[TICK_W-1:0];
  assign need          = CREDIT_W'(rd_bytes) << FRAC_BITS;
  assign delay         = tick - rd_tick;
  assign stat.nonempty = (held != '0);
  assign stat.covers   = (credit >= need);

  // store write at tail, registered read at head
  always_ff @(posedge clk) begin
    if (cmd.accept && arr_ok) begin
      store[tail] <= {packet_bytes, tick};
    end
    if (cmd.rd) begin
      rd_entry <= store[head];
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      credit_per_tick <= RATE_RESET;
      queue_limit     <= LIMIT_RESET;
    end else if (wr_en) begin
      unique case (wr_index)
        CFG_CREDIT_PER_TICK: credit_per_tick <= wr_data[RATE_W-1:0];
        CFG_QUEUE_LIMIT:     queue_limit     <= wr_data[LIMIT_W-1:0];
      endcase
    end
  end

  // queue state, credit and running totals
  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      tail      <= '0;
      held      <= '0;
      credit    <= '0;
      tick      <= '0;
      arrived   <= '0;
      delivered <= '0;
      dropped   <= '0;
      delay_acc <= '0;
    end else begin
      if (cmd.accept) begin
        held   <= held_inc;
        credit <= credit_upd;
        if (arrival_valid) begin
          arrived <= arrived + 1'b1;
        end
        if (arrival_valid && full) begin
          dropped <= dropped + 1'b1;
        end
        if (arr_ok) begin
          tail <= next_slot(tail);
        end
      end
      if (cmd.depart) begin
        held      <= held - 1'b1;
        credit    <= credit - need;
        head      <= next_slot(head);
        delivered <= delivered + 1'b1;
        delay_acc <= delay_acc + DLY_TOT_W'(delay);
      end
      if (cmd.finish) begin
        tick <= tick + 1'b1;
      end
    end
  end

  // per-tick result fields
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      arrival_accepted   <= arr_ok;
      arrival_dropped    <= arrival_valid && full;
      departed_count     <= '0;
      departed_delay_sum <= '0;
    end
    if (cmd.depart) begin
      departed_count     <= departed_count + 1'b1;
      departed_delay_sum <= departed_delay_sum + DLY_SUM_W'(delay);
    end
  end

  assign occupancy        = held;
  assign total_arrived    = arrived;
  assign total_delivered  = delivered;
  assign total_dropped    = dropped;
  assign cumulative_delay = delay_acc;
  assign current_tick     = tick;

endmodule

// File: hw/rtl/drop_tail_fifo_rate_drain.sv
// ----------------------------------------------------------------------------
// drop_tail_fifo_rate_drain
// One tick per start beat: the arrival is queued or tail-dropped, the byte
// credit is refilled (or cleared when the queue is empty), and head packets
// drain one at a time through the head read and credit check loop around the
// single-port packet store while the credit covers them. busy is high from
// the cycle after start is taken until the result beat is gone. Each tick
// gives one result beat, with done high for exactly one cycle; the receiver
// cannot stall it, so it must capture the result fields in that cycle.
// Configuration writes are taken at any cycle with wr_en high and should
// only be made while busy is low.
// ----------------------------------------------------------------------------
module drop_tail_fifo_rate_drain (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  output logic                           done,
  input  logic                           arrival_valid,
  input  logic [dtf_pkg::BYTES_W-1:0]    packet_bytes,
  input  logic                           wr_en,
  input  logic [dtf_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [dtf_pkg::CFG_DATA_W-1:0] wr_data,
  output logic                           arrival_accepted,
  output logic                           arrival_dropped,
  output logic [dtf_pkg::CNT_W-1:0]      departed_count,
  output logic [dtf_pkg::DLY_SUM_W-1:0]  departed_delay_sum,
  output logic [dtf_pkg::CNT_W-1:0]      occupancy,
  output logic [dtf_pkg::TOTAL_W-1:0]    total_arrived,
  output logic [dtf_pkg::TOTAL_W-1:0]    total_delivered,
  output logic [dtf_pkg::TOTAL_W-1:0]    total_dropped,
  output logic [dtf_pkg::DLY_TOT_W-1:0]  cumulative_delay,
  output logic [dtf_pkg::TICK_W-1:0]     current_tick
);
  import dtf_pkg::*;

  dtf_cmd_t  cmd;
  dtf_stat_t stat;

  // tick sequencer
  dtf_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  // queue and accounting datapath
  dtf_datapath u_dp (
    .clk                (clk),
    .rst                (rst),
    .cmd                (cmd),
    .stat               (stat),
    .arrival_valid      (arrival_valid),
    .packet_bytes       (packet_bytes),
    .wr_en              (wr_en),
    .wr_index           (wr_index),
    .wr_data            (wr_data),
    .arrival_accepted   (arrival_accepted),
    .arrival_dropped    (arrival_dropped),
    .departed_count     (departed_count),
    .departed_delay_sum (departed_delay_sum),
    .occupancy          (occupancy),
    .total_arrived      (total_arrived),
    .total_delivered    (total_delivered),
    .total_dropped      (total_dropped),
    .cumulative_delay   (cumulative_delay),
    .current_tick       (current_tick)
  );

endmodule

// File: hw/rtl/dtf_checker.sv
// ----------------------------------------------------------------------------
// dtf_checker
// port-level checks on the tick handshake and the result beat
// ----------------------------------------------------------------------------
`include "drop_tail_fifo_rate_drain_macros.svh"

module dtf_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      start,
  input logic                      busy,
  input logic                      done,
  input logic                      arrival_accepted,
  input logic                      arrival_dropped,
  input logic [dtf_pkg::CNT_W-1:0] occupancy
);
  import dtf_pkg::*;

  // a taken start makes the block busy
  `DTF_ASSERT_NXT(a_start_busy, start && !busy, busy, "start taken but not busy")
  // the result beat only shows while a tick is in flight
  `DTF_ASSERT_IMP(a_done_busy, done, busy, "result beat while idle")
  // the result strobe lasts one cycle and the block then returns to idle
  `DTF_ASSERT_NXT(a_done_pulse, done, !done && !busy, "result beat not single")
  // an arrival is never both queued and dropped, occupancy stays in range
  `DTF_ASSERT_IMP(a_result_sane, done,
    !(arrival_accepted && arrival_dropped) && (occupancy <= DEPTH_CNT),
    "inconsistent result beat")

endmodule

bind drop_tail_fifo_rate_drain dtf_checker u_dtf_checker (.*);

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the drop-tail queue with byte credit drain. A
// clocked driver sends tick beats from a plan queue, with random gaps and
// idle-only register writes. A predictor inside the bench works out the
// status of every tick. The monitor checks each done beat against the oldest
// status still due.
// ----------------------------------------------------------------------------
module tb_top;
  import dtf_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 4;
  localparam int TAIL_CYCLES   = 20;

  typedef enum logic [1:0] {
    PLAN_TICK,
    PLAN_CFG,
    PLAN_HOLD
  } plan_kind_t;

  typedef struct {
    plan_kind_t                kind;
    logic                      valid;
    logic [BYTES_W-1:0]        bytes;
    int unsigned               gap;
    logic [CFG_IDX_W-1:0]      idx;
    logic [CFG_DATA_W-1:0]     data;
  } plan_item_t;

  typedef struct packed {
    logic                  acc;
    logic                  drop;
    logic [CNT_W-1:0]      dep_count;
    logic [DLY_SUM_W-1:0]  dep_delay;
    logic [CNT_W-1:0]      occ;
    logic [TOTAL_W-1:0]    arrived;
    logic [TOTAL_W-1:0]    delivered;
    logic [TOTAL_W-1:0]    dropped;
    logic [DLY_TOT_W-1:0]  delay_total;
    logic [TICK_W-1:0]     tick;
  } tick_status_t;

  // dut signals
  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   start = 1'b0;
  logic                   busy;
  logic                   done;
  logic                   arrival_valid = 1'b0;
  logic [BYTES_W-1:0]     packet_bytes = '0;
  logic                   wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]   wr_index = '0;
  logic [CFG_DATA_W-1:0]  wr_data = '0;
  logic                   arrival_accepted;
  logic                   arrival_dropped;
  logic [CNT_W-1:0]       departed_count;
  logic [DLY_SUM_W-1:0]   departed_delay_sum;
  logic [CNT_W-1:0]       occupancy;
  logic [TOTAL_W-1:0]     total_arrived;
  logic [TOTAL_W-1:0]     total_delivered;
  logic [TOTAL_W-1:0]     total_dropped;
  logic [DLY_TOT_W-1:0]   cumulative_delay;
  logic [TICK_W-1:0]      current_tick;

  // bench bookkeeping
  plan_item_t    tick_plan_q[$];
  tick_status_t  status_due_q[$];
  int unsigned   mismatch_count = 0;
  int unsigned   cycle_count = 0;
  int unsigned   gap_count = 0;
  int unsigned   settle_count = 0;

  // predicted queue state
  logic [BYTES_W-1:0]    size_mem [QUEUE_DEPTH];
  logic [TICK_W-1:0]     arr_tick_mem [QUEUE_DEPTH];
  logic [PTR_W-1:0]      head_ptr;
  logic [PTR_W-1:0]      tail_ptr;
  logic [CNT_W-1:0]      held;
  logic [CREDIT_W-1:0]   credit;
  logic [TICK_W-1:0]     tick_cnt;
  logic [TOTAL_W-1:0]    arrived_cnt;
  logic [TOTAL_W-1:0]    delivered_cnt;
  logic [TOTAL_W-1:0]    dropped_cnt;
  logic [DLY_TOT_W-1:0]  delay_acc;
  logic [RATE_W-1:0]     rate_cfg;
  logic [LIMIT_W-1:0]    limit_cfg;

  drop_tail_fifo_rate_drain u_top (
    .clk                (clk),
    .rst                (rst),
    .start              (start),
    .busy               (busy),
    .done               (done),
    .arrival_valid      (arrival_valid),
    .packet_bytes       (packet_bytes),
    .wr_en              (wr_en),
    .wr_index           (wr_index),
    .wr_data            (wr_data),
    .arrival_accepted   (arrival_accepted),
    .arrival_dropped    (arrival_dropped),
    .departed_count     (departed_count),
    .departed_delay_sum (departed_delay_sum),
    .occupancy          (occupancy),
    .total_arrived      (total_arrived),
    .total_delivered    (total_delivered),
    .total_dropped      (total_dropped),
    .cumulative_delay   (cumulative_delay),
    .current_tick       (current_tick)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor: back to reset state
  function automatic void clear_queue_model();
    head_ptr      = '0;
    tail_ptr      = '0;
    held          = '0;
    credit        = '0;
    tick_cnt      = '0;
    arrived_cnt   = '0;
    delivered_cnt = '0;
    dropped_cnt   = '0;
    delay_acc     = '0;
    rate_cfg      = RATE_RESET;
    limit_cfg     = LIMIT_RESET;
  endfunction

  // predictor: register write
  function automatic void apply_cfg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] data);
    if (idx == CFG_CREDIT_PER_TICK) begin
      rate_cfg = data[RATE_W-1:0];
    end else if (idx == CFG_QUEUE_LIMIT) begin
      limit_cfg = data[LIMIT_W-1:0];
    end
  endfunction

  // predictor: one tick of arrival, credit refill and drain
  function automatic tick_status_t advance_tick(input logic av,
                                                input logic [BYTES_W-1:0] pb);
    tick_status_t          r;
    logic [TICK_W-1:0]     now;
    logic [CREDIT_W:0]     sum;
    logic [CREDIT_W-1:0]   need;
    logic [TICK_W-1:0]     dly;
    logic                  draining;
    r   = '0;
    now = tick_cnt;

    // arrival: tail drop at the limit or at full depth
    if (av) begin
      arrived_cnt = arrived_cnt + 1'b1;
      if (held >= limit_cfg || held >= DEPTH_CNT) begin
        r.drop      = 1'b1;
        dropped_cnt = dropped_cnt + 1'b1;
      end else begin
        size_mem[tail_ptr]     = pb;
        arr_tick_mem[tail_ptr] = now;
        tail_ptr = tail_ptr + 1'b1;
        held     = held + 1'b1;
        r.acc    = 1'b1;
      end
    end

    // credit refill, saturating; cleared on an empty queue
    if (held != 0) begin
      sum = {1'b0, credit} + rate_cfg;
      credit = (sum > {1'b0, CREDIT_MAX}) ? CREDIT_MAX : sum[CREDIT_W-1:0];
    end else begin
      credit = '0;
    end

    // drain head packets while the credit covers them
    draining = 1'b1;
    while (draining) begin
      if (held == 0) begin
        draining = 1'b0;
      end else begin
        need = CREDIT_W'(size_mem[head_ptr]) << FRAC_BITS;
        if (credit < need) begin
          draining = 1'b0;
        end else begin
          credit        = credit - need;
          dly           = now - arr_tick_mem[head_ptr];
          r.dep_count   = r.dep_count + 1'b1;
          r.dep_delay   = r.dep_delay + dly;
          delay_acc     = delay_acc + dly;
          delivered_cnt = delivered_cnt + 1'b1;
          head_ptr      = head_ptr + 1'b1;
          held          = held - 1'b1;
        end
      end
    end

    r.occ         = held;
    r.arrived     = arrived_cnt;
    r.delivered   = delivered_cnt;
    r.dropped     = dropped_cnt;
    r.delay_total = delay_acc;
    r.tick        = now;
    tick_cnt      = tick_cnt + 1'b1;
    return r;
  endfunction

  // field compare with report
  function automatic void check_field(input logic [TICK_W-1:0] tick, input string name,
                                      input logic [63:0] want, input logic [63:0] got);
    if (got !== want) begin
      $display("%0t: tick %0d %s mismatch, expected %0h actual %0h",
               $time, tick, name, want, got);
      mismatch_count++;
    end
  endfunction

  // plan builders
  function automatic void plan_tick(input logic v, input logic [BYTES_W-1:0] b,
                                    input int unsigned gap);
    plan_item_t it;
    it       = '{kind: PLAN_TICK, default: '0};
    it.kind  = PLAN_TICK;
    it.valid = v;
    it.bytes = b;
    it.gap   = gap;
    tick_plan_q.push_back(it);
  endfunction

  function automatic void plan_cfg(input logic [CFG_IDX_W-1:0] idx,
                                   input logic [CFG_DATA_W-1:0] data);
    plan_item_t it;
    it      = '{kind: PLAN_CFG, default: '0};
    it.kind = PLAN_CFG;
    it.idx  = idx;
    it.data = data;
    tick_plan_q.push_back(it);
  endfunction

  function automatic void plan_hold();
    plan_item_t it;
    it      = '{kind: PLAN_HOLD, default: '0};
    it.kind = PLAN_HOLD;
    tick_plan_q.push_back(it);
  endfunction

  // limit write with random upper data bits, which the block ignores
  function automatic void plan_limit(input logic [LIMIT_W-1:0] lim);
    plan_cfg(CFG_QUEUE_LIMIT, {16'($urandom), lim});
  endfunction

  // packet size: mostly small so the drain keeps up, or uniform over 16 bits
  function automatic logic [BYTES_W-1:0] rand_bytes(input bit full);
    if (full) return BYTES_W'($urandom_range(0, 65535));
    if ($urandom_range(0, 9) == 0) return BYTES_W'($urandom_range(0, 1023));
    return BYTES_W'($urandom_range(0, 63));
  endfunction

  // random ticks; each phase opens with a stretch of back-to-back beats
  function automatic void plan_phase(input int n, input int arrival_pct, input bit full);
    bit          quiet;
    logic        v;
    int unsigned gap;
    quiet = 1'b1;
    for (int i = 0; i < n; i++) begin
      if (i >= 15 && (i % 20) == 0) quiet = ($urandom_range(0, 2) == 0);
      if ($urandom_range(0, 49) == 0) plan_hold();
      v   = ($urandom_range(0, 99) < arrival_pct);
      gap = quiet ? 0 : $urandom_range(0, 9);
      plan_tick(v, v ? rand_bytes(full) : BYTES_W'($urandom_range(0, 65535)), gap);
    end
  endfunction

  // driver: tick beats, register writes and holds from the plan queue
  always @(posedge clk) begin : tick_driver
    logic        nxt_start;
    logic        nxt_wr;
    plan_item_t  it;
    nxt_start = start;
    nxt_wr    = 1'b0;
    if (rst) begin
      clear_queue_model();
      nxt_start    = 1'b0;
      gap_count    = 0;
      settle_count = 0;
    end else begin
      // idle cycles with nothing due, for writes and holds
      if (status_due_q.size() == 0 && !busy && !start && !wr_en) begin
        settle_count++;
      end else begin
        settle_count = 0;
      end

      // beat taken at this edge
      if (start && !busy) begin
        status_due_q.push_back(advance_tick(arrival_valid, packet_bytes));
        nxt_start = 1'b0;
        gap_count = 0;
      end

      if (!nxt_start && tick_plan_q.size() != 0) begin
        it = tick_plan_q[0];
        case (it.kind)
          PLAN_TICK: begin
            if (gap_count >= it.gap) begin
              void'(tick_plan_q.pop_front());
              arrival_valid <= it.valid;
              packet_bytes  <= it.bytes;
              nxt_start = 1'b1;
              gap_count = 0;
            end else begin
              gap_count++;
            end
          end
          PLAN_CFG: begin
            if (settle_count >= SETTLE_CYCLES) begin
              void'(tick_plan_q.pop_front());
              wr_index <= it.idx;
              wr_data  <= it.data;
              nxt_wr = 1'b1;
              apply_cfg(it.idx, it.data);
              settle_count = 0;
            end
          end
          default: begin
            if (settle_count >= SETTLE_CYCLES) void'(tick_plan_q.pop_front());
          end
        endcase
      end
    end
    start <= nxt_start;
    wr_en <= nxt_wr;
  end

  // monitor: every done beat against the oldest status due
  always @(posedge clk) begin : status_monitor
    tick_status_t want;
    if (!rst && done) begin
      if (status_due_q.size() == 0) begin
        $display("%0t: result beat with no tick pending, expected none actual tick %0d",
                 $time, current_tick);
        mismatch_count++;
      end else begin
        want = status_due_q.pop_front();
        check_field(want.tick, "arrival_accepted", want.acc, arrival_accepted);
        check_field(want.tick, "arrival_dropped", want.drop, arrival_dropped);
        check_field(want.tick, "departed_count", want.dep_count, departed_count);
        check_field(want.tick, "departed_delay_sum", want.dep_delay, departed_delay_sum);
        check_field(want.tick, "occupancy", want.occ, occupancy);
        check_field(want.tick, "total_arrived", want.arrived, total_arrived);
        check_field(want.tick, "total_delivered", want.delivered, total_delivered);
        check_field(want.tick, "total_dropped", want.dropped, total_dropped);
        check_field(want.tick, "cumulative_delay", want.delay_total, cumulative_delay);
        check_field(want.tick, "current_tick", want.tick, current_tick);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // stimulus plan, reset and end of run
  initial begin
    // directed: ignored bytes, zero-byte and one-byte packets, credit clear
    plan_tick(1'b0, 16'hFFFF, $urandom_range(0, 9));
    plan_tick(1'b1, 16'h0000, $urandom_range(0, 9));
    plan_tick(1'b1, 16'h0001, $urandom_range(0, 9));
    plan_tick(1'b0, 16'h0000, $urandom_range(0, 9));
    plan_tick(1'b1, 16'h0002, $urandom_range(0, 9));
    plan_tick(1'b0, 16'h1234, $urandom_range(0, 9));
    // zero limit drops everything
    plan_limit(8'd0);
    plan_tick(1'b1, 16'hFFFF, $urandom_range(0, 9));
    plan_tick(1'b1, 16'h0000, $urandom_range(0, 9));
    // limit of two with no credit, then a limit below occupancy
    plan_limit(8'd2);
    plan_cfg(CFG_CREDIT_PER_TICK, 24'd0);
    plan_tick(1'b1, 16'h0005, 0);
    plan_tick(1'b1, 16'h0005, 0);
    plan_tick(1'b1, 16'h0005, $urandom_range(0, 9));
    plan_tick(1'b1, 16'h0000, $urandom_range(0, 9));
    plan_limit(8'd1);
    plan_tick(1'b1, 16'h0003, $urandom_range(0, 9));
    plan_tick(1'b0, 16'h0000, $urandom_range(0, 9));
    // full rate: several departures in one tick
    plan_cfg(CFG_CREDIT_PER_TICK, 24'hFFFFFF);
    plan_limit(8'd128);
    plan_tick(1'b1, 16'h0009, $urandom_range(0, 9));
    plan_tick(1'b1, 16'h0007, $urandom_range(0, 9));
    plan_tick(1'b0, 16'h0000, $urandom_range(0, 9));
    plan_hold();

    // random: fast drain at the depth limit
    plan_phase(90, 70, 1'b0);
    // random: moderate rate, small limit
    plan_cfg(CFG_CREDIT_PER_TICK, 24'($urandom_range(1 << 12, 1 << 21)));
    plan_limit(8'($urandom_range(1, 16)));
    plan_phase(80, 80, 1'b0);
    // random: no credit, limit above depth, fill up to the depth drop
    plan_cfg(CFG_CREDIT_PER_TICK, 24'd0);
    plan_limit(8'd255);
    plan_phase(140, 95, 1'b0);
    // limit lowered below occupancy
    plan_limit(8'd4);
    plan_phase(15, 100, 1'b0);
    // full rate drains the backlog
    plan_cfg(CFG_CREDIT_PER_TICK, 24'hFFFFFF);
    plan_limit(8'd128);
    plan_phase(50, 40, 1'b0);
    // back to reset settings after a full pause
    plan_hold();
    plan_cfg(CFG_CREDIT_PER_TICK, RATE_RESET);
    plan_limit(LIMIT_RESET);
    plan_phase(35, 50, 1'b0);
    // full-range sizes at full rate
    plan_cfg(CFG_CREDIT_PER_TICK, 24'hFFFFFF);
    plan_limit(8'd128);
    plan_phase(40, 30, 1'b1);

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // wait for every beat to be taken and every status to arrive
    do begin
      @(posedge clk);
    end while (tick_plan_q.size() != 0 || start || status_due_q.size() != 0);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && status_due_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/dtf_pkg.sv
hw/rtl/dtf_ctrl.sv
hw/rtl/dtf_datapath.sv
hw/rtl/drop_tail_fifo_rate_drain.sv
hw/rtl/dtf_checker.sv
tb/tb_top.sv
